// ----- sv/utf8d_pkg.sv -----
// Package for the UTF-8 stream decoder: decoder state and result types,
// and the byte ranges of the lead bytes. No dependencies.
package utf8d_pkg;

    // Lead byte ranges, sequences of one to six bytes
    localparam logic [7:0] ASCII_HI  = 8'd127;
    localparam logic [7:0] LEAD2_LO  = 8'd192;
    localparam logic [7:0] LEAD2_HI  = 8'd223;
    localparam logic [7:0] LEAD3_LO  = 8'd224;
    localparam logic [7:0] LEAD3_HI  = 8'd239;
    localparam logic [7:0] LEAD4_LO  = 8'd240;
    localparam logic [7:0] LEAD4_HI  = 8'd247;
    localparam logic [7:0] LEAD5_LO  = 8'd248;
    localparam logic [7:0] LEAD5_HI  = 8'd251;
    localparam logic [7:0] LEAD6_LO  = 8'd252;
    localparam logic [7:0] LEAD6_HI  = 8'd253;
    // Offset removed from each continuation byte
    localparam logic [31:0] CONT_BIAS = 32'd128;

    // Bits of payload a continuation byte contributes
    localparam int unsigned CONT_BITS = 6;

    typedef struct packed {
        logic [2:0]  owed;   // continuation bytes still owed
        logic [31:0] acc;    // partial code point, wraps modulo 2^32
    } t_dec_state;

    typedef struct packed {
        logic        emit;   // a character completes on this byte
        logic [31:0] value;  // its code point
    } t_dec_result;

endpackage

// ----- sv/utf8d_decode.sv -----
// Single-byte decode step: next decoder state and optional result.
// Depends on utf8d_pkg.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_dec_state  o_state,
    output t_dec_result o_result
);

    logic [31:0] cont_sum;
    logic [2:0]  owed_dec;

    // Shift in six bits and remove the continuation bias, unchecked
    assign cont_sum = {i_state.acc[31-CONT_BITS:0], {CONT_BITS{1'b0}}}
                    + {24'd0, i_byte} - CONT_BIAS;
    assign owed_dec = i_state.owed - 3'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '{emit: 1'b0, value: 32'd0};
        if (i_state.owed == 3'd0) begin
            // Classify the lead byte; stray and invalid leads are dropped
            if (i_byte <= ASCII_HI) begin
                o_result = '{emit: 1'b1, value: {24'd0, i_byte}};
            end else if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                o_state = '{owed: 3'd1, acc: {27'd0, i_byte[4:0]}};
            end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                o_state = '{owed: 3'd2, acc: {28'd0, i_byte[3:0]}};
            end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                o_state = '{owed: 3'd3, acc: {29'd0, i_byte[2:0]}};
            end else if (i_byte >= LEAD5_LO && i_byte <= LEAD5_HI) begin
                o_state = '{owed: 3'd4, acc: {30'd0, i_byte[1:0]}};
            end else if (i_byte >= LEAD6_LO && i_byte <= LEAD6_HI) begin
                o_state = '{owed: 3'd5, acc: {31'd0, i_byte[0]}};
            end
        end else begin
            // Accumulate a continuation byte, emit when nothing is owed
            o_state = '{owed: owed_dec, acc: cont_sum};
            if (owed_dec == 3'd0) begin
                o_result = '{emit: 1'b1, value: cont_sum};
                o_state.acc = 32'd0;
            end
        end
        // End of buffer drops any partial character
        if (i_last) begin
            o_state = '{owed: 3'd0, acc: 32'd0};
        end
    end

endmodule

// ----- sv/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: input register, decode step,
// result register. Depends on utf8d_pkg and utf8d_decode.
//
//   channel   direction  tdata          tlast          tuser
//   s_axis    in         in_byte[7:0]   buffer_end     -
//   m_axis    out        code_point     closes_buffer  -
//
// One byte is taken every cycle while m_axis does not stall; a completing byte
// waits in the input register and its result in the result register. The rate is
// set by the single decode step between the two registers.
// Reset (synchronous, active low) empties both registers and clears the
// decoder state. A stall on m_axis holds the result register, then the
// input register, and then drops s_axis_tready.
module utf8_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] code_point
    output logic        m_axis_tlast    // closes_buffer
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_result n_result;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_last;
    logic        advance;

    // Move the held beat into the result stage when it has room
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    utf8d_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Decoder state advances once per decoded beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{owed: 3'd0, acc: 32'd0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.emit) begin
            r_out_value <= n_result.value;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- tb/sv/utf8_stream_decoder_checker.sv -----
// Checker for the UTF-8 stream decoder: follows both stream channels, predicts
// each decoded character and compares it with what the block emits.
// Depends on utf8d_pkg for the decoder state type and the lead byte ranges.
module utf8_stream_decoder_checker
    import utf8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_code,
    input  logic        i_out_end,
    output int          o_fail_count,
    output int          o_chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] code;
        logic        closes;
    } t_char;

    t_char      expected_chars[$];
    t_dec_state decoder = '0;
    int         fails = 0;
    int         pending = 0;

    assign o_fail_count    = fails;
    assign o_chars_pending = pending;

    // Advance the decoder by one byte; return the character it completes, if any
    function automatic t_dec_result decode_step(input t_dec_state cur, input logic [7:0] b,
                                                input logic last, output t_dec_state nxt);
        t_dec_result res;
        res = '0;
        nxt = cur;
        if (cur.owed == 3'd0) begin
            if (b <= ASCII_HI) begin
                res.emit  = 1'b1;
                res.value = {24'd0, b};
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                nxt.owed = 3'd1;
                nxt.acc  = {24'd0, 8'(b - LEAD2_LO)};
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                nxt.owed = 3'd2;
                nxt.acc  = {24'd0, 8'(b - LEAD3_LO)};
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                nxt.owed = 3'd3;
                nxt.acc  = {24'd0, 8'(b - LEAD4_LO)};
            end else if (b >= LEAD5_LO && b <= LEAD5_HI) begin
                nxt.owed = 3'd4;
                nxt.acc  = {24'd0, 8'(b - LEAD5_LO)};
            end else if (b >= LEAD6_LO && b <= LEAD6_HI) begin
                nxt.owed = 3'd5;
                nxt.acc  = {24'd0, 8'(b - LEAD6_LO)};
            end
            // stray continuation bytes and 0xFE/0xFF leave the state alone
        end else begin
            // continuation is not checked; low bytes make the sum wrap
            nxt.acc  = (cur.acc << CONT_BITS) + {24'd0, b} - CONT_BIAS;
            nxt.owed = cur.owed - 3'd1;
            if (nxt.owed == 3'd0) begin
                res.emit  = 1'b1;
                res.value = nxt.acc;
                nxt.acc   = '0;
            end
        end
        // end of buffer drops any partial character
        if (last)
            nxt = '0;
        return res;
    endfunction

    // Compare emitted characters, then predict from the accepted input beat
    always @(posedge i_clk) begin
        t_dec_result res;
        t_dec_state  nxt;
        t_char       want;
        if (!i_rst_n) begin
            decoder = '0;
            expected_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected beat: code_point %h closes_buffer %b",
                           i_out_code, i_out_end);
                    fails++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_code !== want.code) begin
                        $error("code_point: expected %h, actual %h", want.code, i_out_code);
                        fails++;
                    end
                    if (i_out_end !== want.closes) begin
                        $error("closes_buffer: expected %b, actual %b",
                               want.closes, i_out_end);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                res     = decode_step(decoder, i_in_byte, i_in_end, nxt);
                decoder = nxt;
                if (res.emit) begin
                    want = '{code: res.value, closes: i_in_end};
                    expected_chars = {expected_chars, want};
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

// ----- tb/sv/utf8_stream_decoder_unit_test.sv -----
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on utf8_stream_decoder_unit and
// utf8_stream_decoder_checker.
module utf8_stream_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1130;
    localparam int CYCLE_LIMIT  = 100000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        quiet = 1'b0;
    int          cycle_count = 0;
    int          fail_count;
    int          chars_pending;

    utf8_stream_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    utf8_stream_decoder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_tvalid),
        .i_in_ready      (s_tready),
        .i_in_byte       (s_tdata),
        .i_in_end        (s_tlast),
        .i_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .i_out_code      (m_tdata),
        .i_out_end       (m_tlast),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always #5 i_clk = ~i_clk;

    // Stall the receiver at random, except in the quiet stretch
    always @(negedge i_clk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 15);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive one beat, with an occasional gap ahead of it; return at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender until every predicted character has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (chars_pending != 0)
            @(negedge i_clk);
    endtask

    // Send one character of random length and content, mostly well-formed
    task automatic send_char(output int n);
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        n = (pick < 40) ? 1 : (pick < 60) ? 2 : (pick < 75) ? 3 :
            (pick < 87) ? 4 : (pick < 94) ? 5 : 6;
        case (n)
            1:       b = 8'($urandom_range(0, 127));
            2:       b = 8'($urandom_range(192, 223));
            3:       b = 8'($urandom_range(224, 239));
            4:       b = 8'($urandom_range(240, 247));
            5:       b = 8'($urandom_range(248, 251));
            default: b = 8'($urandom_range(252, 253));
        endcase
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                // mostly proper continuations, now and then any byte
                if ($urandom_range(0, 9) == 0)
                    b = 8'($urandom);
                else
                    b = {2'b10, 6'($urandom)};
            end
            send_byte(b, $urandom_range(0, 29) == 0);
        end
    endtask

    initial begin : stimulus
        logic [8:0] directed [24];
        int         sent;
        int         n;
        bit         mid_drained;
        // {buffer_end, byte}
        directed = '{9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0FE, 9'h0FF,
                     9'h0C0, 9'h005,
                     9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
                     9'h0E1, 9'h180,
                     9'h141,
                     9'h0C3, 9'h1A9,
                     9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080};
        sent = 0;
        mid_drained = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: ASCII ends, stray leads, wrap, six bytes, cut-off, buffer ends
        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][8]);
        drain();

        // Random: mostly well-formed characters, some raw noise
        while (sent < RANDOM_BYTES) begin
            quiet = (sent >= 400 && sent < 650);
            if (!mid_drained && sent >= RANDOM_BYTES / 2) begin
                drain();
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                sent++;
            end else begin
                send_char(n);
                sent += n;
            end
        end
        quiet = 1'b0;

        // Flush and let any stray beat show up
        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && chars_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8_stream_decoder_unit.sv
tb/sv/utf8_stream_decoder_checker.sv
tb/sv/utf8_stream_decoder_unit_test.sv
